// ===== hw/rtl/ktsm_pkg.sv =====
`timescale 1ns / 1ps

package ktsm_pkg;

    // Table geometry, fixed by the widths of the request and result fields.
    localparam int MAX_ENTRIES = 16;
    localparam int MAX_LEN     = 32;
    localparam int ENTRY_W     = 4;
    localparam int POS_W       = 5;
    localparam int LEN_W       = 6;
    localparam int CHAR_W      = 8;
    localparam int TRIG_DEPTH  = MAX_ENTRIES * MAX_LEN;

    // Request function codes.
    localparam logic [2:0] FUNC_KEY         = 3'd0;
    localparam logic [2:0] FUNC_WRITE_CHAR  = 3'd1;
    localparam logic [2:0] FUNC_COMMIT      = 3'd2;
    localparam logic [2:0] FUNC_CLEAR_TABLE = 3'd3;
    localparam logic [2:0] FUNC_CLEAR_HIST  = 3'd4;

    // Printable character range.
    localparam logic [CHAR_W-1:0] PRINT_LOW  = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_HIGH = 8'h7E;

    typedef struct packed {
        logic [2:0]         func;
        logic [CHAR_W-1:0]  character;
        logic               key_pressed;
        logic               shortcut_held;
        logic               modifier_key;
        logic [ENTRY_W-1:0] entry_index;
        logic [POS_W-1:0]   char_position;
        logic [LEN_W-1:0]   trigger_length;
    } t_req;

    typedef struct packed {
        logic [ENTRY_W-1:0] matched_entry;
        logic [LEN_W-1:0]   erase_count;
    } t_res;

endpackage

// ===== hw/rtl/ktsm_ram.sv =====
`timescale 1ns / 1ps

module ktsm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/keystroke_trigger_suffix_matcher.sv =====
`timescale 1ns / 1ps

// Keystroke trigger suffix matcher.
// Request channel (i_req_valid / o_req_ready / i_req) carries key events and
// table maintenance: write a trigger character, commit a trigger length, clear
// the table or clear the typed history. Result channel (o_res_valid /
// i_res_ready / o_res) carries one result per key press that completes a
// trigger: the matched entry and the number of characters to erase.
// Requests are handled one at a time. A commit sweeps the length table for the
// new longest trigger. A printable key press scans the entries, skipping those
// that cannot match, and compares each candidate in the character compare loop,
// which reads one trigger character and one history character per cycle from
// two RAMs. Other requests finish without leaving the idle state.
// Reset empties the trigger table and the history; trigger characters and
// history characters are held in RAM and are not cleared.
// A result waits in an output register while the receiver stalls; new requests
// are still taken, and only a further match waits until that register frees.

module keystroke_trigger_suffix_matcher
    import ktsm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    localparam int TRIG_AW = $clog2(TRIG_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    localparam logic [ENTRY_W-1:0] LAST_ENTRY = ENTRY_W'(MAX_ENTRIES - 1);
    localparam logic [LEN_W-1:0]   LEN_MAX    = LEN_W'(MAX_LEN);

    logic [2:0]         r_state, n_state;
    logic [LEN_W-1:0]   r_len [MAX_ENTRIES];
    logic [LEN_W-1:0]   n_len [MAX_ENTRIES];
    logic [LEN_W-1:0]   r_longest, n_longest;
    logic [LEN_W-1:0]   r_count, n_count;
    logic [POS_W-1:0]   r_wp, n_wp;
    logic [ENTRY_W-1:0] r_entry, n_entry;
    logic [LEN_W-1:0]   r_cur_len, n_cur_len;
    logic [LEN_W-1:0]   r_iss, n_iss;
    logic               r_pend, n_pend;
    logic               r_last, n_last;
    logic [LEN_W-1:0]   r_best_len, n_best_len;
    logic [ENTRY_W-1:0] r_best_entry, n_best_entry;
    logic               r_found, n_found;
    logic               r_res_valid, n_res_valid;
    t_res               r_res, n_res;

    logic               req_fire;
    logic               is_print;
    logic               push;
    logic               trig_we;
    logic [LEN_W-1:0]   cur_len;
    logic [LEN_W-1:0]   commit_len;
    logic [TRIG_AW-1:0] trig_waddr;
    logic [TRIG_AW-1:0] trig_raddr;
    logic [POS_W-1:0]   hist_raddr;
    logic [CHAR_W-1:0]  trig_rdata;
    logic [CHAR_W-1:0]  hist_rdata;

    // Request handshake and key classification.
    assign o_req_ready = (r_state == S_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;
    assign is_print    = (i_req.character >= PRINT_LOW) && (i_req.character <= PRINT_HIGH);
    assign push        = req_fire && (i_req.func == FUNC_KEY) && i_req.key_pressed
                         && (r_longest != '0) && !i_req.shortcut_held && is_print;
    assign cur_len     = r_len[r_entry];
    assign commit_len  = (i_req.trigger_length > LEN_MAX) ? LEN_MAX : i_req.trigger_length;

    // Trigger character RAM, addressed by entry and character position.
    assign trig_we    = req_fire && (i_req.func == FUNC_WRITE_CHAR);
    assign trig_waddr = {i_req.entry_index, i_req.char_position};
    assign trig_raddr = {r_entry, r_iss[POS_W-1:0]};

    ktsm_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(TRIG_DEPTH)
    ) u_trig_ram (
        .i_clk  (i_clk),
        .i_we   (trig_we),
        .i_waddr(trig_waddr),
        .i_wdata(i_req.character),
        .i_raddr(trig_raddr),
        .o_rdata(trig_rdata)
    );

    // History ring buffer; the window ends just before the write pointer.
    assign hist_raddr = r_wp - r_cur_len[POS_W-1:0] + r_iss[POS_W-1:0];

    ktsm_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(MAX_LEN)
    ) u_hist_ram (
        .i_clk  (i_clk),
        .i_we   (push),
        .i_waddr(r_wp),
        .i_wdata(i_req.character),
        .i_raddr(hist_raddr),
        .o_rdata(hist_rdata)
    );

    // Control sequencer.
    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_longest    = r_longest;
        n_count      = r_count;
        n_wp         = r_wp;
        n_entry      = r_entry;
        n_cur_len    = r_cur_len;
        n_iss        = r_iss;
        n_pend       = r_pend;
        n_last       = r_last;
        n_best_len   = r_best_len;
        n_best_entry = r_best_entry;
        n_found      = r_found;
        n_res_valid  = r_res_valid;
        n_res        = r_res;

        if (r_res_valid && i_res_ready) begin
            n_res_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    case (i_req.func)
                        FUNC_KEY: begin
                            if (i_req.key_pressed && (r_longest != '0)) begin
                                if (i_req.shortcut_held) begin
                                    n_count = '0;
                                end else if (!is_print) begin
                                    if (!i_req.modifier_key) begin
                                        n_count = '0;
                                    end
                                end else begin
                                    n_wp       = r_wp + 1'b1;
                                    n_count    = (r_count >= r_longest) ? r_longest
                                                                        : r_count + 1'b1;
                                    n_entry    = '0;
                                    n_best_len = '0;
                                    n_found    = 1'b0;
                                    n_state    = S_SCAN;
                                end
                            end
                        end
                        FUNC_COMMIT: begin
                            n_len[i_req.entry_index] = commit_len;
                            n_count   = '0;
                            n_longest = '0;
                            n_entry   = '0;
                            n_state   = S_SWEEP;
                        end
                        FUNC_CLEAR_TABLE: begin
                            for (int e = 0; e < MAX_ENTRIES; e++) begin
                                n_len[e] = '0;
                            end
                            n_longest = '0;
                            n_count   = '0;
                        end
                        FUNC_CLEAR_HIST: begin
                            n_count = '0;
                        end
                        default: begin
                            // Character writes go straight to the RAM.
                        end
                    endcase
                end
            end

            S_SWEEP: begin
                // One table entry per cycle toward the longest length.
                if (cur_len > r_longest) begin
                    n_longest = cur_len;
                end
                n_entry = r_entry + 1'b1;
                if (r_entry == LAST_ENTRY) begin
                    n_state = S_IDLE;
                end
            end

            S_SCAN: begin
                // Skip entries that are empty, too long, or cannot beat the best.
                if ((cur_len == '0) || (cur_len > r_count) || (cur_len <= r_best_len)) begin
                    n_entry = r_entry + 1'b1;
                    n_state = (r_entry == LAST_ENTRY) ? S_FIN : S_SCAN;
                end else begin
                    n_cur_len = cur_len;
                    n_iss     = '0;
                    n_pend    = 1'b0;
                    n_state   = S_CMP;
                end
            end

            S_CMP: begin
                // Issue the next character pair while checking the previous one.
                if (r_iss < r_cur_len) begin
                    n_iss  = r_iss + 1'b1;
                    n_pend = 1'b1;
                    n_last = ((r_iss + 1'b1) == r_cur_len);
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (trig_rdata != hist_rdata) begin
                        n_entry = r_entry + 1'b1;
                        n_state = (r_entry == LAST_ENTRY) ? S_FIN : S_SCAN;
                    end else if (r_last) begin
                        n_found      = 1'b1;
                        n_best_len   = r_cur_len;
                        n_best_entry = r_entry;
                        n_entry      = r_entry + 1'b1;
                        n_state      = (r_entry == LAST_ENTRY) ? S_FIN : S_SCAN;
                    end
                end
            end

            S_FIN: begin
                // Hand the winner to the output register once it is free.
                if (!r_found) begin
                    n_state = S_IDLE;
                end else if (!r_res_valid || i_res_ready) begin
                    n_res_valid         = 1'b1;
                    n_res.matched_entry = r_best_entry;
                    n_res.erase_count   = r_best_len;
                    n_count             = '0;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_longest   <= '0;
            r_count     <= '0;
            r_wp        <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_res_valid <= 1'b0;
            for (int e = 0; e < MAX_ENTRIES; e++) begin
                r_len[e] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_longest   <= n_longest;
            r_count     <= n_count;
            r_wp        <= n_wp;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_res_valid <= n_res_valid;
            r_len       <= n_len;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_entry      <= n_entry;
        r_cur_len    <= n_cur_len;
        r_iss        <= n_iss;
        r_last       <= n_last;
        r_best_len   <= n_best_len;
        r_best_entry <= n_best_entry;
        r_res        <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ===== hw/rtl/ktsm_checker.sv =====
`timescale 1ns / 1ps

module ktsm_checker
    import ktsm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input logic o_res_valid,
    input logic i_res_ready,
    input t_res o_res
);

    // A stalled result holds its value.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("result changed or dropped while stalled");

    // Erase count is always a legal trigger length.
    a_erase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.erase_count != '0)
                        && (o_res.erase_count <= LEN_W'(MAX_LEN)))
        else $error("erase count out of range");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    // A result never appears in the cycle right after a request is taken.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !$rose(o_res_valid))
        else $error("result raised directly after a request");

endmodule

bind keystroke_trigger_suffix_matcher ktsm_checker u_ktsm_checker (.*);
